### design/pijb_pkg.sv
// Package for the position-indexed jitter buffer.
// Holds transaction payload types, operation and status codes, default sizes.
// No dependencies.
`timescale 1ns / 1ps
package pijb_pkg;

  localparam int DEPTH_DEFAULT      = 4096;
  localparam int FRAME_BITS_DEFAULT = 32;

  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_COMMIT = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_SLID = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] position;
    logic [31:0] frame_data;
    logic [11:0] read_offset;
    logic [12:0] release_count;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
    logic [31:0] synced_frames;
    logic [31:0] written_total;
  } rsp_t;

endpackage

### design/pijb_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on pijb_pkg.
`timescale 1ns / 1ps
interface pijb_req_if;
  import pijb_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pijb_rsp_if;
  import pijb_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/position_indexed_jitter_buffer_unit.sv
// Jitter buffer top level: ring frame store addressed by absolute stream position.
// Sequence: a dropped write goes straight to the result; other transactions first reduce an
// offset mod DEPTH (by reciprocal when DEPTH is not a power of two), then apply it; a read then
// waits for the store output and a commit zeroes min(count, DEPTH) slots. One transaction at a
// time: req.ready is high only in the idle state. Reset: synchronous; clears control state,
// then a clearing pass zeroes the store with req.ready low. A finished result waits in the
// output register while the next transaction is accepted.
`timescale 1ns / 1ps
module position_indexed_jitter_buffer_unit #(
  parameter int DEPTH      = pijb_pkg::DEPTH_DEFAULT,
  parameter int FRAME_BITS = pijb_pkg::FRAME_BITS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  pijb_req_if.sink   req,
  pijb_rsp_if.source rsp
);
  import pijb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam bit POW2 = (DEPTH & (DEPTH - 1)) == 0;
  localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] DEPTH_M1 = AW'(DEPTH - 1);
  localparam logic [31:0]   DEPTH32  = 32'(DEPTH);
  localparam logic [31:0]   DEPTH_M1_32 = 32'(DEPTH - 1);
  localparam logic [31:0]   RECIP    = 32'((64'd1 << 32) / DEPTH);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_APPLY  = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  logic [2:0]            state;
  logic                  started;
  logic [AW-1:0]         head_slot;
  logic [31:0]           head_position;
  logic [31:0]           highest_position;
  logic [31:0]           accepted_count;

  logic [1:0]            op;
  logic [31:0]           pos;
  logic [FRAME_BITS-1:0] wr_data;
  logic [AW-1:0]         off;
  logic [12:0]           cnt;
  logic [1:0]            status;
  logic [31:0]           mod_val;
  logic [AW-1:0]         rem;
  logic [1:0]            step;
  logic [63:0]           mod_prod;
  logic [31:0]           mod_qd;
  logic [AW-1:0]         clear_slot;
  logic [12:0]           clear_left;
  logic [31:0]           rd;

  logic                  rsp_valid;
  rsp_t                  rsp_data;

  logic [FRAME_BITS-1:0] mem [DEPTH];
  logic [FRAME_BITS-1:0] mem_q;
  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         mem_waddr;
  logic [AW-1:0]         mem_raddr;
  logic [FRAME_BITS-1:0] mem_wdata;

  logic [31:0]           hp_eff;
  logic [31:0]           wr_off;
  logic [63:0]           din64;
  logic [63:0]           q64;
  logic [31:0]           mod_diff;
  logic [31:0]           pos_next;
  logic                  out_free;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;
  assign out_free  = !rsp_valid || rsp.ready;

  always_comb begin
    hp_eff   = started ? head_position : req.data.position;
    wr_off   = req.data.position - hp_eff;
    din64    = {32'd0, req.data.frame_data};
    q64      = '0;
    q64[FRAME_BITS-1:0] = mem_q;
    mod_diff = mod_val - mod_qd;
    pos_next = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = clear_slot;
    mem_wdata = '0;
    mem_raddr = add_mod(head_slot, rem);
    case (state)
      S_CLEAR, S_COMMIT: begin
        mem_we = 1'b1;
      end
      S_APPLY: begin
        if (op == FUNC_WRITE) begin
          mem_we    = 1'b1;
          mem_waddr = add_mod(add_mod(head_slot, rem), off);
          mem_wdata = wr_data;
        end else if (op == FUNC_READ) begin
          mem_re = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      started          <= 1'b0;
      head_slot        <= '0;
      head_position    <= '0;
      highest_position <= '0;
      accepted_count   <= '0;
      clear_slot       <= '0;
      clear_left       <= '0;
      step             <= '0;
      rsp_valid        <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clear_slot <= (clear_slot == DEPTH_M1) ? '0 : clear_slot + 1'b1;
          if (clear_slot == DEPTH_M1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            op      <= req.data.func;
            pos     <= req.data.position;
            wr_data <= din64[FRAME_BITS-1:0];
            cnt     <= req.data.release_count;
            rd      <= '0;
            rem     <= '0;
            step    <= '0;
            case (req.data.func)
              FUNC_WRITE: begin
                started <= 1'b1;
                if (req.data.position < hp_eff) begin
                  head_position <= hp_eff;
                  status        <= ST_DROP;
                  mod_val       <= '0;
                  off           <= '0;
                  state         <= S_FIN;
                end else if (wr_off > DEPTH_M1_32) begin
                  head_position <= req.data.position - DEPTH_M1_32;
                  status        <= ST_SLID;
                  mod_val       <= wr_off - DEPTH_M1_32;
                  off           <= DEPTH_M1;
                  state         <= S_MOD;
                end else begin
                  head_position <= hp_eff;
                  status        <= ST_OK;
                  mod_val       <= '0;
                  off           <= wr_off[AW-1:0];
                  state         <= S_MOD;
                end
              end
              FUNC_READ: begin
                status  <= ST_OK;
                mod_val <= {20'd0, req.data.read_offset};
                off     <= '0;
                state   <= S_MOD;
              end
              FUNC_COMMIT: begin
                status  <= ST_OK;
                mod_val <= {19'd0, req.data.release_count};
                off     <= '0;
                state   <= S_MOD;
              end
              default: begin
                status  <= ST_OK;
                mod_val <= '0;
                off     <= '0;
                state   <= S_MOD;
              end
            endcase
          end
        end
        S_MOD: begin
          if (POW2) begin
            rem   <= mod_val[AW-1:0];
            state <= S_APPLY;
          end else begin
            // quotient estimate by reciprocal, low by at most one
            step <= step + 1'b1;
            case (step)
              2'd0: begin
                mod_prod <= {32'd0, mod_val} * {32'd0, RECIP};
              end
              2'd1: begin
                mod_qd <= mod_prod[63:32] * DEPTH32;
              end
              default: begin
                rem   <= (mod_diff >= DEPTH32) ? AW'(mod_diff - DEPTH32) : mod_diff[AW-1:0];
                state <= S_APPLY;
              end
            endcase
          end
        end
        S_APPLY: begin
          case (op)
            FUNC_WRITE: begin
              head_slot      <= add_mod(head_slot, rem);
              accepted_count <= accepted_count + 32'd1;
              if (highest_position < pos_next) begin
                highest_position <= pos_next;
              end
              state <= S_FIN;
            end
            FUNC_READ: begin
              state <= S_RDWAIT;
            end
            FUNC_COMMIT: begin
              head_slot     <= add_mod(head_slot, rem);
              head_position <= head_position + {19'd0, cnt};
              clear_slot    <= head_slot;
              clear_left    <= ({19'd0, cnt} < DEPTH32) ? cnt : 13'(DEPTH);
              state         <= (cnt != '0) ? S_COMMIT : S_FIN;
            end
            default: begin
              state <= S_FIN;
            end
          endcase
        end
        S_RDWAIT: begin
          rd    <= q64[31:0];
          state <= S_FIN;
        end
        S_COMMIT: begin
          clear_slot <= (clear_slot == DEPTH_M1) ? '0 : clear_slot + 1'b1;
          clear_left <= clear_left - 1'b1;
          if (clear_left == 13'd1) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            rsp_valid              <= 1'b1;
            rsp_data.read_data     <= rd;
            rsp_data.status        <= status;
            rsp_data.synced_frames <= (highest_position > head_position) ?
                                      highest_position - head_position : 32'd0;
            rsp_data.written_total <= accepted_count;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/pijb_checker.sv
// Port-level assertions for the jitter buffer top level, with the bind that attaches them.
// Depends on pijb_pkg and position_indexed_jitter_buffer_unit.
`timescale 1ns / 1ps
module pijb_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input pijb_pkg::rsp_t    rsp_data
);
  import pijb_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response changed while stalled");

  a_reset_no_rsp: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("request taken during clearing pass");

  a_status_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != ST_OK |-> rsp_data.read_data == 32'd0)
    else $error("write transaction carries read data");

endmodule

bind position_indexed_jitter_buffer_unit pijb_checker u_pijb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
